[hw/rtl/sfc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfc_pkg
// shared types and constants for the sync frame capture block
// ----------------------------------------------------------------------------
package sfc_pkg;

  localparam int DATA_W            = 8;
  localparam int INDEX_W           = 6;
  localparam int COUNT_W           = 16;
  localparam int CFG_INDEX_W       = 2;

  localparam int PAYLOAD_BYTES_DEF = 40;

  typedef logic [DATA_W-1:0]      data_t;
  typedef logic [INDEX_W-1:0]     index_t;
  typedef logic [COUNT_W-1:0]     count_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  // configuration register indexes
  localparam cfg_index_t REG_FIRST_SYNC  = 2'd0;
  localparam cfg_index_t REG_SECOND_SYNC = 2'd1;
  localparam cfg_index_t REG_END_MARKER  = 2'd2;

  // register reset values
  localparam data_t FIRST_SYNC_RST  = 8'hFF;
  localparam data_t SECOND_SYNC_RST = 8'h8A;
  localparam data_t END_MARKER_RST  = 8'h0A;

endpackage

[hw/rtl/sfc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfc_if
// valid/ready channels for received bytes and for frame bytes
// ----------------------------------------------------------------------------
interface sfc_in_if;
  import sfc_pkg::*;

  logic  valid;
  logic  ready;
  data_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfc_out_if;
  import sfc_pkg::*;

  logic   valid;
  logic   ready;
  data_t  frame_byte;
  index_t byte_index;
  logic   last;
  count_t frame_number;

  modport source (output valid, output frame_byte, output byte_index, output last,
                  output frame_number, input ready);
  modport sink   (input valid, input frame_byte, input byte_index, input last,
                  input frame_number, output ready);
endinterface

[hw/rtl/sfc_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfc_cell
// one byte cell of the frame store chain, loads from its neighbor on shift
// ----------------------------------------------------------------------------
module sfc_cell (
  input  logic          clk,
  input  logic          shift,
  input  sfc_pkg::data_t din,
  output sfc_pkg::data_t dout
);
  import sfc_pkg::*;

  data_t held;

  always_ff @(posedge clk) begin
    if (shift) begin
      held <= din;
    end
  end

  assign dout = held;

endmodule

[hw/rtl/sync_frame_capture.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_frame_capture
// fixed-length frame deframer: two sync bytes, payload, end marker check
// ----------------------------------------------------------------------------
// throughput: one received byte per cycle while hunting or collecting
// a good frame is replayed as PAYLOAD_BYTES+2 output items, one per cycle when
//   the sink is ready; input is held off (ready low) for that whole replay
// latency: first header item is offered the cycle after the end marker byte
// reset (rst, synchronous): hunt for first sync, frame count 0, registers to
//   defaults; the byte chain itself is not cleared
// ----------------------------------------------------------------------------
module sync_frame_capture #(
  parameter int PAYLOAD_BYTES = sfc_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  sfc_pkg::cfg_index_t   cfg_index,
  input  sfc_pkg::data_t        cfg_data,
  sfc_in_if.sink                rx_ch,
  sfc_out_if.source             tx_ch
);
  import sfc_pkg::*;

  localparam int CNT_W = (PAYLOAD_BYTES > 2) ? $clog2(PAYLOAD_BYTES) : 1;

  typedef enum logic [1:0] {
    ST_SEEK1,
    ST_SEEK2,
    ST_DATA,
    ST_EMIT
  } state_t;

  // configuration registers
  data_t first_sync;
  data_t second_sync;
  data_t end_marker;

  // control
  state_t           state;
  logic [CNT_W-1:0] payload_count;
  index_t           emit_index;
  count_t           good_frames;

  logic rx_fire;
  logic tx_fire;
  logic chain_shift;

  // byte chain: cell 0 takes the newest byte, last cell holds the oldest
  data_t tap [PAYLOAD_BYTES];

  assign rx_fire = rx_ch.valid & rx_ch.ready;
  assign tx_fire = tx_ch.valid & tx_ch.ready;

  // shift in while collecting, shift out once the two headers are gone
  assign chain_shift = (rx_fire && state == ST_DATA) ||
                       (tx_fire && emit_index >= index_t'(2));

  for (genvar i = 0; i < PAYLOAD_BYTES; i++) begin : g_cell
    if (i == 0) begin : g_head
      sfc_cell u_cell (
        .clk   (clk),
        .shift (chain_shift),
        .din   (rx_ch.rx_byte),
        .dout  (tap[i])
      );
    end else begin : g_body
      sfc_cell u_cell (
        .clk   (clk),
        .shift (chain_shift),
        .din   (tap[i-1]),
        .dout  (tap[i])
      );
    end
  end

  // configuration writes, unknown index ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      first_sync  <= FIRST_SYNC_RST;
      second_sync <= SECOND_SYNC_RST;
      end_marker  <= END_MARKER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIRST_SYNC:  first_sync  <= cfg_data;
        REG_SECOND_SYNC: second_sync <= cfg_data;
        REG_END_MARKER:  end_marker  <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_SEEK1;
      payload_count <= '0;
      emit_index    <= '0;
      good_frames   <= '0;
    end else begin
      unique case (state)
        ST_SEEK1: begin
          if (rx_fire && rx_ch.rx_byte == first_sync) begin
            state <= ST_SEEK2;
          end
        end
        ST_SEEK2: begin
          // other bytes are ignored, no fall back to the hunt
          if (rx_fire && rx_ch.rx_byte == second_sync) begin
            state         <= ST_DATA;
            payload_count <= '0;
          end
        end
        ST_DATA: begin
          if (rx_fire) begin
            if (payload_count == CNT_W'(PAYLOAD_BYTES - 1)) begin
              payload_count <= '0;
              if (rx_ch.rx_byte == end_marker) begin
                state       <= ST_EMIT;
                emit_index  <= '0;
                good_frames <= good_frames + count_t'(1);
              end else begin
                // bad end marker, drop silently
                state <= ST_SEEK1;
              end
            end else begin
              payload_count <= payload_count + CNT_W'(1);
            end
          end
        end
        ST_EMIT: begin
          if (tx_fire) begin
            if (emit_index == index_t'(PAYLOAD_BYTES + 1)) begin
              state      <= ST_SEEK1;
              emit_index <= '0;
            end else begin
              emit_index <= emit_index + index_t'(1);
            end
          end
        end
        default: state <= ST_SEEK1;
      endcase
    end
  end

  assign rx_ch.ready = (state != ST_EMIT);

  // output item: headers first, then the oldest cell of the chain
  assign tx_ch.valid        = (state == ST_EMIT);
  assign tx_ch.frame_byte   = (emit_index == index_t'(0)) ? first_sync  :
                              (emit_index == index_t'(1)) ? second_sync :
                              tap[PAYLOAD_BYTES-1];
  assign tx_ch.byte_index   = emit_index;
  assign tx_ch.last         = (emit_index == index_t'(PAYLOAD_BYTES + 1));
  assign tx_ch.frame_number = good_frames;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks sync_frame_capture: received bytes go in, frames come out. A local
// deframer model follows every accepted byte and queues the frame items it
// must produce; each output item is checked field by field against the
// oldest one. Directed tests cover defaults, the second sync wait, dropped
// frames, register extremes and back-pressure; random traffic follows.
// ----------------------------------------------------------------------------
module testbench;
  import sfc_pkg::*;

  localparam int PAYLOAD       = PAYLOAD_BYTES_DEF;
  localparam int FRAME_ITEMS   = PAYLOAD + 2;
  localparam int RANDOM_ITEMS  = 40;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 400;
  localparam int PRINT_LIMIT   = 40;

  // index with no register behind it, writes there must be ignored
  localparam cfg_index_t REG_UNUSED = 2'd3;

  // payload fill that toggles every bit of a byte
  localparam data_t FILL_PATTERN [4] = '{8'h00, 8'hFF, 8'h55, 8'hAA};

  typedef enum logic [1:0] {
    HUNT_FIRST  = 2'd0,
    HUNT_SECOND = 2'd1,
    COLLECT     = 2'd2
  } hunt_t;

  typedef struct {
    data_t  value;
    index_t idx;
    logic   last;
    count_t num;
  } frame_item_t;

  logic       clk;
  logic       rst       = 1'b1;
  logic       cfg_we    = 1'b0;
  cfg_index_t cfg_index = REG_FIRST_SYNC;
  data_t      cfg_data  = '0;

  sfc_in_if  rx_ch ();
  sfc_out_if tx_ch ();

  sync_frame_capture #(
    .PAYLOAD_BYTES (PAYLOAD)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx_ch     (rx_ch),
    .tx_ch     (tx_ch)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // register mirror, follows every write the bench makes
  data_t  cur_first  = FIRST_SYNC_RST;
  data_t  cur_second = SECOND_SYNC_RST;
  data_t  cur_end    = END_MARKER_RST;

  // deframer state mirror
  hunt_t  phase            = HUNT_FIRST;
  int     stored           = 0;
  data_t  payload_store [PAYLOAD];
  count_t good_frame_count = '0;

  // frame items still owed by the block, oldest first
  frame_item_t awaited_frame_bytes [$];

  int mismatches = 0;

  // idle knobs, changed per test
  int  send_gap_max  = 15;
  int  sink_stall_max = 15;
  int  hold_request  = 0;
  bit  rx_offering   = 1'b0;

  // ------------------------------------------------------------------------
  // model of the deframer, run once per accepted received byte
  // ------------------------------------------------------------------------
  function automatic void deframe_predict(data_t b);
    frame_item_t it;
    case (phase)
      HUNT_SECOND: begin
        // anything but the second sync is dropped, the hunt is not restarted
        if (b == cur_second) begin
          phase  = COLLECT;
          stored = 0;
        end
      end
      COLLECT: begin
        payload_store[stored] = b;
        stored++;
        if (stored == PAYLOAD) begin
          phase  = HUNT_FIRST;
          stored = 0;
          // bad end marker: frame gone, count untouched
          if (b == cur_end) begin
            good_frame_count++;
            for (int k = 0; k < FRAME_ITEMS; k++) begin
              if (k == 0)      it.value = cur_first;
              else if (k == 1) it.value = cur_second;
              else             it.value = payload_store[k-2];
              it.idx  = index_t'(k);
              it.last = (k == FRAME_ITEMS - 1);
              it.num  = good_frame_count;
              awaited_frame_bytes.push_back(it);
            end
          end
        end
      end
      // first sync hunt, the unused phase code lands here as well
      default: phase = (b == cur_first) ? HUNT_SECOND : HUNT_FIRST;
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // output side: ready pattern in its own process
  // ------------------------------------------------------------------------
  initial begin : sink_side
    int held;
    int stall;
    bit ready_on;
    ready_on = 1'b0;
    tx_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      // long hold-off, counted here while the sender keeps pushing
      if (hold_request > 0) begin
        held = hold_request;
        hold_request = 0;
        if (ready_on) tx_ch.ready <= 1'b0;
        ready_on = 1'b0;
        repeat (held) @(posedge clk);
      end
      stall = $urandom_range(0, sink_stall_max);
      if (stall > 0) begin
        if (ready_on) tx_ch.ready <= 1'b0;
        ready_on = 1'b0;
        repeat (stall) @(posedge clk);
      end
      if (!ready_on) begin
        tx_ch.ready <= 1'b1;
        ready_on = 1'b1;
      end
      // ready is up, the next edge with valid takes the item
      do @(posedge clk); while (!tx_ch.valid);
    end
  end

  // ------------------------------------------------------------------------
  // output checker
  // ------------------------------------------------------------------------
  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin
    frame_item_t want;
    if (!rst && tx_ch.valid && tx_ch.ready) begin
      if (awaited_frame_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
          $display("%0t ns: unexpected item, expected none, actual byte %0h index %0d",
                   $time, tx_ch.frame_byte, tx_ch.byte_index);
      end else begin
        want = awaited_frame_bytes.pop_front();
        check_field("frame_byte",   32'(want.value), 32'(tx_ch.frame_byte));
        check_field("byte_index",   32'(want.idx),   32'(tx_ch.byte_index));
        check_field("last",         32'(want.last),  32'(tx_ch.last));
        check_field("frame_number", 32'(want.num),   32'(tx_ch.frame_number));
      end
    end
  end

  // ------------------------------------------------------------------------
  // shared stimulus tasks
  // ------------------------------------------------------------------------
  // one received byte, with a random gap ahead of it
  task automatic send_byte(data_t b);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      if (rx_offering) rx_ch.valid <= 1'b0;
      rx_offering = 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    rx_offering = 1'b1;
    do @(posedge clk); while (!rx_ch.ready);
    deframe_predict(b);
  endtask

  // payload bytes; the byte at the end marker slot is good or corrupted
  task automatic send_payload(bit end_ok, bit patterned, int len);
    data_t b;
    for (int k = 0; k < len; k++) begin
      if (k == PAYLOAD - 1)
        b = end_ok ? cur_end : cur_end ^ data_t'($urandom_range(1, 255));
      else if (patterned)
        b = FILL_PATTERN[k % 4];
      else
        b = data_t'($urandom);
      send_byte(b);
    end
  endtask

  task automatic send_frame(bit end_ok, bit patterned);
    send_byte(cur_first);
    send_byte(cur_second);
    send_payload(end_ok, patterned, PAYLOAD);
  endtask

  // stop offering and wait until every owed frame item has come out
  task automatic wait_drained();
    if (rx_offering) rx_ch.valid <= 1'b0;
    rx_offering = 1'b0;
    wait (awaited_frame_bytes.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, only with the block quiet
  task automatic write_reg(cfg_index_t idx, data_t val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FIRST_SYNC:  cur_first  = val;
      REG_SECOND_SYNC: cur_second = val;
      REG_END_MARKER:  cur_end    = val;
      default: ;
    endcase
  endtask

  task automatic write_all_regs(data_t s1, data_t s2, data_t em);
    write_reg(REG_FIRST_SYNC,  s1);
    write_reg(REG_SECOND_SYNC, s2);
    write_reg(REG_END_MARKER,  em);
  endtask

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------
  // reset values of the registers, payload toggling every bit
  task automatic test_default_frame();
    send_gap_max   = 15;
    sink_stall_max = 15;
    send_frame(1'b1, 1'b1);
  endtask

  // stray bytes while waiting for the second sync, the first sync among them
  task automatic test_second_sync_wait();
    send_gap_max   = 3;
    sink_stall_max = 3;
    send_byte(cur_first);
    send_byte(cur_first);
    send_byte(cur_second ^ 8'h01);
    send_byte(8'h00);
    send_byte(cur_second);
    send_payload(1'b1, 1'b0, PAYLOAD);
  endtask

  // wrong end marker: nothing out, the next good frame keeps the count going
  task automatic test_bad_end_marker();
    send_frame(1'b0, 1'b0);
  endtask

  // register extremes, a write to the empty index, then back to defaults
  task automatic test_register_settings();
    send_gap_max   = 7;
    sink_stall_max = 7;
    write_all_regs(8'h00, 8'h00, 8'h00);
    send_frame(1'b1, 1'b1);
    write_all_regs(8'hFF, 8'hFF, 8'hFF);
    write_reg(REG_UNUSED, 8'h3C);
    send_frame(1'b1, 1'b1);
    write_all_regs(FIRST_SYNC_RST, SECOND_SYNC_RST, END_MARKER_RST);
  endtask

  // no idling on either side
  task automatic test_back_to_back();
    send_gap_max   = 0;
    sink_stall_max = 0;
    send_frame(1'b1, 1'b0);
  endtask

  // sink holds off long enough that the block stalls its input
  task automatic test_backpressure();
    send_gap_max   = 0;
    sink_stall_max = 2;
    hold_request   = LONG_HOLD;
    send_frame(1'b1, 1'b0);
    send_frame(1'b1, 1'b0);
    // sender pauses until the whole backlog is out
    wait_drained();
  endtask

  // mostly well-formed frames, some broken ones and line noise
  task automatic test_random();
    int sent;
    int pick;
    int len;
    data_t s;
    s = data_t'($urandom);
    write_all_regs(s, ($urandom_range(0, 1) == 0) ? s : data_t'($urandom),
                   data_t'($urandom));
    send_gap_max   = 2;
    sink_stall_max = 15;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_frame(1'b1, 1'b0);
        sent += FRAME_ITEMS;
      end else if (pick < 78) begin
        send_frame(1'b0, 1'b0);
        sent += FRAME_ITEMS;
      end else if (pick < 88) begin
        // frame cut short, the following bytes fill its payload
        len = $urandom_range(1, PAYLOAD - 1);
        send_byte(cur_first);
        send_byte(cur_second);
        send_payload(1'b1, 1'b0, len);
        sent += len + 2;
      end else begin
        len = $urandom_range(1, 6);
        repeat (len) send_byte(data_t'($urandom));
        sent += len;
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // sequence
  // ------------------------------------------------------------------------
  initial begin
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_frame();
    test_second_sync_wait();
    test_bad_end_marker();
    test_register_settings();
    test_back_to_back();
    test_backpressure();
    test_random();

    wait_drained();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
